@@ hw/rtl/rme_pkg.sv @@
package rme_pkg;

  localparam int EntryW      = 16;
  localparam int AngleW      = 16;
  localparam int ThrW        = 15;
  localparam int CordicSteps = 16;
  localparam int SumW        = 2 * (EntryW + 1) - 2;
  localparam int SqrtSteps   = SumW / 2;
  localparam int SyW         = EntryW + 1;
  localparam int OpW         = EntryW + 1;
  localparam int XyW         = OpW + 15;
  localparam int ZW          = 34;
  localparam int AngleLimit  = 25736;
  localparam int CordicLat   = CordicSteps + 2;
  localparam int Latency     = 2 + SqrtSteps + CordicLat;

  localparam logic [2:0] AddrThreshold = 3'd0;

  typedef struct packed {
    logic signed [EntryW-1:0] m00;
    logic signed [EntryW-1:0] m10;
    logic signed [EntryW-1:0] m11;
    logic signed [EntryW-1:0] m12;
    logic signed [EntryW-1:0] m20;
    logic signed [EntryW-1:0] m21;
    logic signed [EntryW-1:0] m22;
  } mat_t;

  // atan(2^-i) in Q30 radians, rounded to nearest
  function automatic logic signed [ZW-1:0] ang_q30(input int i);
    logic signed [ZW-1:0] a;
    case (i)
      0:  a = ZW'(843314857);
      1:  a = ZW'(497837829);
      2:  a = ZW'(263043837);
      3:  a = ZW'(133525159);
      4:  a = ZW'(67021687);
      5:  a = ZW'(33543516);
      6:  a = ZW'(16775851);
      7:  a = ZW'(8388437);
      8:  a = ZW'(4194283);
      9:  a = ZW'(2097149);
      10: a = ZW'(1048576);
      default: begin
        if (i <= 30) a = ZW'(64'sd1 <<< (30 - i));
        else a = '0;
      end
    endcase
    return a;
  endfunction

endpackage

@@ hw/rtl/rme_sqrt.sv @@
module rme_sqrt import rme_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  mat_t           mat_i,
  output logic           valid_o,
  output mat_t           mat_o,
  output logic [SyW-1:0] sy_o
);

  logic [SumW-1:0] rem_q [SqrtSteps+1];
  logic [SumW:0]   res_q [SqrtSteps+1];
  mat_t            mat_q [SqrtSteps+1];
  logic            vld_q [SqrtSteps+1];

  logic [OpW-1:0]     abs_a, abs_b;
  logic [2*OpW-1:0]   sq_a, sq_b;
  logic [SumW-1:0]    sum_d;

  always_comb begin
    abs_a = mat_i.m00[EntryW-1] ? OpW'(-{mat_i.m00[EntryW-1], mat_i.m00})
                                : OpW'({1'b0, mat_i.m00});
    abs_b = mat_i.m10[EntryW-1] ? OpW'(-{mat_i.m10[EntryW-1], mat_i.m10})
                                : OpW'({1'b0, mat_i.m10});
    sq_a  = {{OpW{1'b0}}, abs_a} * {{OpW{1'b0}}, abs_a};
    sq_b  = {{OpW{1'b0}}, abs_b} * {{OpW{1'b0}}, abs_b};
    sum_d = sq_a[SumW-1:0] + sq_b[SumW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= sum_d;
    res_q[0] <= '0;
    mat_q[0] <= mat_i;
  end

  // one result bit per stage, restoring
  for (genvar k = 0; k < SqrtSteps; k++) begin : g_step
    localparam logic [SumW:0] Bit = (SumW+1)'(1) << (2 * (SqrtSteps - 1 - k));
    logic [SumW:0]   trial;
    logic [SumW-1:0] rem_d;
    logic [SumW:0]   res_d;

    always_comb begin
      trial = res_q[k] + Bit;
      if ({1'b0, rem_q[k]} >= trial) begin
        rem_d = rem_q[k] - trial[SumW-1:0];
        res_d = (res_q[k] >> 1) + Bit;
      end else begin
        rem_d = rem_q[k];
        res_d = res_q[k] >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k+1] <= rem_d;
      res_q[k+1] <= res_d;
      mat_q[k+1] <= mat_q[k];
    end
  end

  assign valid_o = vld_q[SqrtSteps];
  assign mat_o   = mat_q[SqrtSteps];
  assign sy_o    = res_q[SqrtSteps][SyW-1:0];

endmodule

@@ hw/rtl/rme_cordic.sv @@
module rme_cordic import rme_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic signed [OpW-1:0]    y_i,
  input  logic signed [OpW-1:0]    x_i,
  output logic                     valid_o,
  output logic signed [AngleW-1:0] angle_o
);

  logic signed [XyW-1:0] x_q [CordicSteps+1];
  logic signed [XyW-1:0] y_q [CordicSteps+1];
  logic signed [ZW-1:0]  z_q [CordicSteps+1];
  logic                  zero_q [CordicSteps+1];
  logic                  vld_q [CordicSteps+1];

  logic signed [XyW-1:0] xs, ys, x0_d, y0_d;
  logic signed [ZW-1:0]  z0_d;

  // scale by 4096, fold left half plane into the right
  always_comb begin
    xs = {{(XyW-OpW-12){x_i[OpW-1]}}, x_i, 12'b0};
    ys = {{(XyW-OpW-12){y_i[OpW-1]}}, y_i, 12'b0};
    x0_d = xs;
    y0_d = ys;
    z0_d = '0;
    if (xs < 0) begin
      if (ys >= 0) begin
        x0_d = ys;
        y0_d = -xs;
        z0_d = ang_q30(0) <<< 1;
      end else begin
        x0_d = -ys;
        y0_d = xs;
        z0_d = -(ang_q30(0) <<< 1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]    <= x0_d;
    y_q[0]    <= y0_d;
    z_q[0]    <= z0_d;
    zero_q[0] <= (x_i == '0) && (y_i == '0);
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_iter
    localparam logic signed [ZW-1:0] Ang = ang_q30(i);
    logic signed [XyW-1:0] x_d, y_d;
    logic signed [ZW-1:0]  z_d;

    always_comb begin
      if (y_q[i] >= 0) begin
        x_d = x_q[i] + (y_q[i] >>> i);
        y_d = y_q[i] - (x_q[i] >>> i);
        z_d = z_q[i] + Ang;
      end else begin
        x_d = x_q[i] - (y_q[i] >>> i);
        y_d = y_q[i] + (x_q[i] >>> i);
        z_d = z_q[i] - Ang;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      x_q[i+1]    <= x_d;
      y_q[i+1]    <= y_d;
      z_q[i+1]    <= z_d;
      zero_q[i+1] <= zero_q[i];
    end
  end

  logic signed [ZW-1:0]     z_rnd;
  logic signed [ZW-18:0]    r;
  logic signed [AngleW-1:0] angle_d;
  logic                     vld_out_q;

  // Q30 to Q13, round half up, clamp to +-pi; a zero input vector gives zero
  always_comb begin
    z_rnd = z_q[CordicSteps] + ZW'(65536);
    r     = z_rnd[ZW-1:17];
    if (zero_q[CordicSteps]) angle_d = '0;
    else if (r > (ZW-17)'(AngleLimit)) angle_d = AngleW'(AngleLimit);
    else if (r < -(ZW-17)'(AngleLimit)) angle_d = -AngleW'(AngleLimit);
    else angle_d = r[AngleW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_out_q <= 1'b0;
    end else begin
      vld_out_q <= vld_q[CordicSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    angle_o <= angle_d;
  end

  assign valid_o = vld_out_q;

endmodule

@@ hw/rtl/rotation_matrix_to_euler_angles.sv @@
// Channel   Handshake        Payload
// command   start / busy     m00_i m10_i m11_i m12_i m20_i m21_i m22_i
// result    valid_o strobe   roll_o pitch_o yaw_o singular_o
// config    APB write/read   singular_threshold at byte address 0
//
// One matrix per cycle; busy is never raised.
// Pipeline: input register, squaring, 16 square-root stages,
// then 18 CORDIC stages (fold, 16 rotations, rounding) in three lanes.
// Reset clears the valid bits and sets the threshold to 1.
// Results are strobed for one cycle; the receiver cannot stall.
module rotation_matrix_to_euler_angles import rme_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [EntryW-1:0] m00_i,
  input  logic signed [EntryW-1:0] m10_i,
  input  logic signed [EntryW-1:0] m11_i,
  input  logic signed [EntryW-1:0] m12_i,
  input  logic signed [EntryW-1:0] m20_i,
  input  logic signed [EntryW-1:0] m21_i,
  input  logic signed [EntryW-1:0] m22_i,
  output logic                     valid_o,
  output logic signed [AngleW-1:0] roll_o,
  output logic signed [AngleW-1:0] pitch_o,
  output logic signed [AngleW-1:0] yaw_o,
  output logic                     singular_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  logic [ThrW-1:0] thr_q;
  logic            in_vld_q;
  mat_t            mat_q;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign prdata = (paddr == AddrThreshold) ? {{(32-ThrW){1'b0}}, thr_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= ThrW'(1);
      in_vld_q <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr == AddrThreshold) begin
        thr_q <= pwdata[ThrW-1:0];
      end
      in_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    mat_q <= '{m00: m00_i, m10: m10_i, m11: m11_i, m12: m12_i,
               m20: m20_i, m21: m21_i, m22: m22_i};
  end

  logic           sq_vld;
  mat_t           sq_mat;
  logic [SyW-1:0] sy;

  rme_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_vld_q),
    .mat_i   (mat_q),
    .valid_o (sq_vld),
    .mat_o   (sq_mat),
    .sy_o    (sy)
  );

  logic                  sing;
  logic signed [OpW-1:0] roll_y, roll_x, pitch_y, pitch_x, yaw_y, yaw_x;

  // yaw with both operands zero comes out as zero
  always_comb begin
    sing    = {1'b0, sy} < {{(SyW+1-ThrW){1'b0}}, thr_q};
    pitch_y = -OpW'(sq_mat.m20);
    pitch_x = OpW'($signed({1'b0, sy}));
    if (sing) begin
      roll_y = -OpW'(sq_mat.m12);
      roll_x = OpW'(sq_mat.m11);
      yaw_y  = '0;
      yaw_x  = '0;
    end else begin
      roll_y = OpW'(sq_mat.m21);
      roll_x = OpW'(sq_mat.m22);
      yaw_y  = OpW'(sq_mat.m10);
      yaw_x  = OpW'(sq_mat.m00);
    end
  end

  logic sing_q [CordicLat];

  always_ff @(posedge clk_i) begin
    sing_q[0] <= sing;
    for (int i = 1; i < CordicLat; i++) sing_q[i] <= sing_q[i-1];
  end

  logic roll_vld, pitch_vld, yaw_vld;

  rme_cordic u_roll (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (sq_vld),
    .y_i (roll_y), .x_i (roll_x), .valid_o (roll_vld), .angle_o (roll_o)
  );

  rme_cordic u_pitch (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (sq_vld),
    .y_i (pitch_y), .x_i (pitch_x), .valid_o (pitch_vld), .angle_o (pitch_o)
  );

  rme_cordic u_yaw (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (sq_vld),
    .y_i (yaw_y), .x_i (yaw_x), .valid_o (yaw_vld), .angle_o (yaw_o)
  );

  assign valid_o    = roll_vld && pitch_vld && yaw_vld;
  assign singular_o = sing_q[CordicLat-1];

endmodule

@@ hw/rtl/rme_checker.sv @@
module rme_checker import rme_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     start,
  input logic                     busy,
  input logic                     valid_o,
  input logic signed [AngleW-1:0] roll_o,
  input logic signed [AngleW-1:0] pitch_o,
  input logic signed [AngleW-1:0] yaw_o,
  input logic                     singular_o
);

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Latency valid_o)
    else $error("accepted command produced no result on time");

  a_yaw_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && singular_o) |-> (yaw_o == '0))
    else $error("singular result with nonzero yaw");

  a_roll_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (roll_o <= AngleW'(AngleLimit) && roll_o >= -AngleW'(AngleLimit)))
    else $error("roll outside +-pi");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (pitch_o <= AngleW'(AngleLimit) && pitch_o >= -AngleW'(AngleLimit)))
    else $error("pitch outside +-pi");

endmodule

bind rotation_matrix_to_euler_angles rme_checker u_rme_checker (.*);
